/* design/qgi_pkg.sv */
package qgi_pkg;

    // Fixed widths of the sample and result words.
    localparam int RATE_W = 23;
    localparam int DT_W   = 16;
    localparam int ATT_W  = 32;

    // Half-angle gain: pi / 360e9 scaled by 2^61.
    localparam int                GAIN_W  = 25;
    localparam logic [GAIN_W-1:0] DQ_GAIN = 25'd20122276;

    // |rate| * interval is split in two halves for the gain multiply.
    localparam int P_W    = 38;
    localparam int P_LO_W = 19;
    localparam int HACC_W = 64;

    localparam int                STEP_W    = 5;
    localparam logic [STEP_W-1:0] LAST_STEP = 5'd31;

    // Rate axes and quaternion components.
    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;
    localparam logic [1:0] C_W  = 2'd0;
    localparam logic [1:0] C_X  = 2'd1;
    localparam logic [1:0] C_Y  = 2'd2;
    localparam logic [1:0] C_Z  = 2'd3;
    localparam logic       ADD  = 1'b0;
    localparam logic       SUB  = 1'b1;

    typedef enum logic [2:0] {
        K_NOP,
        K_RATE,
        K_GAIN_LO,
        K_GAIN_HI,
        K_QUAT,
        K_SQUARE,
        K_NEWTON,
        K_FINAL
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [1:0] axis;
        logic [1:0] qi;
        logic [1:0] vi;
        logic       sub;
    } t_op;

    typedef struct packed {
        t_op  op;
        logic neg;
    } t_tag;

    function automatic t_op mk(input t_kind kind, input logic [1:0] axis,
                               input logic [1:0] qi, input logic [1:0] vi,
                               input logic sub);
        t_op op;
        op.kind = kind;
        op.axis = axis;
        op.qi   = qi;
        op.vi   = vi;
        op.sub  = sub;
        return op;
    endfunction

    // Operation issued to the shared multiplier at each sequencer step.
    // A result is written back in the step after its issue, so an operation that
    // takes a result as an operand is issued only after that result is written back.
    function automatic t_op op_at(input logic [STEP_W-1:0] step);
        t_op op;
        op = mk(K_NOP, AX_X, C_W, C_W, ADD);
        case (step)
            5'd0:  op = mk(K_RATE,    AX_X, C_W, C_W, ADD);
            5'd1:  op = mk(K_RATE,    AX_Y, C_W, C_W, ADD);
            5'd2:  op = mk(K_RATE,    AX_Z, C_W, C_W, ADD);
            5'd3:  op = mk(K_GAIN_LO, AX_X, C_W, C_W, ADD);
            5'd4:  op = mk(K_GAIN_HI, AX_X, C_W, C_W, ADD);
            5'd5:  op = mk(K_GAIN_LO, AX_Y, C_W, C_W, ADD);
            5'd6:  op = mk(K_GAIN_HI, AX_Y, C_W, C_W, ADD);
            5'd7:  op = mk(K_GAIN_LO, AX_Z, C_W, C_W, ADD);
            5'd8:  op = mk(K_GAIN_HI, AX_Z, C_W, C_W, ADD);
            5'd9:  op = mk(K_QUAT,    AX_X, C_X, C_W, SUB);
            5'd10: op = mk(K_QUAT,    AX_X, C_W, C_X, ADD);
            5'd11: op = mk(K_QUAT,    AX_X, C_Z, C_Y, ADD);
            5'd12: op = mk(K_QUAT,    AX_X, C_Y, C_Z, SUB);
            5'd13: op = mk(K_QUAT,    AX_Y, C_Y, C_W, SUB);
            5'd14: op = mk(K_QUAT,    AX_Y, C_Z, C_X, SUB);
            5'd15: op = mk(K_QUAT,    AX_Y, C_W, C_Y, ADD);
            5'd16: op = mk(K_QUAT,    AX_Y, C_X, C_Z, ADD);
            5'd17: op = mk(K_QUAT,    AX_Z, C_Z, C_W, SUB);
            5'd18: op = mk(K_QUAT,    AX_Z, C_Y, C_X, ADD);
            5'd19: op = mk(K_QUAT,    AX_Z, C_X, C_Y, SUB);
            5'd20: op = mk(K_QUAT,    AX_Z, C_W, C_Z, ADD);
            5'd21: op = mk(K_SQUARE,  AX_X, C_W, C_W, ADD);
            5'd22: op = mk(K_SQUARE,  AX_X, C_W, C_X, ADD);
            5'd23: op = mk(K_SQUARE,  AX_X, C_W, C_Y, ADD);
            5'd24: op = mk(K_SQUARE,  AX_X, C_W, C_Z, ADD);
            5'd25: op = mk(K_NEWTON,  AX_X, C_W, C_W, ADD);
            5'd26: op = mk(K_NOP,     AX_X, C_W, C_W, ADD);
            5'd27: op = mk(K_FINAL,   AX_X, C_W, C_W, ADD);
            5'd28: op = mk(K_FINAL,   AX_X, C_W, C_X, ADD);
            5'd29: op = mk(K_FINAL,   AX_X, C_W, C_Y, ADD);
            5'd30: op = mk(K_FINAL,   AX_X, C_W, C_Z, ADD);
            default: op = mk(K_NOP,   AX_X, C_W, C_W, ADD);
        endcase
        return op;
    endfunction

endpackage

/* design/qgi_if.sv */
interface qgi_in_if import qgi_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [RATE_W-1:0] rate_x;
    logic signed [RATE_W-1:0] rate_y;
    logic signed [RATE_W-1:0] rate_z;
    logic        [DT_W-1:0]   interval_us;

    modport source (output valid, rate_x, rate_y, rate_z, interval_us, input ready);
    modport sink   (input valid, rate_x, rate_y, rate_z, interval_us, output ready);
endinterface

interface qgi_out_if import qgi_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [ATT_W-1:0] att_w;
    logic signed [ATT_W-1:0] att_x;
    logic signed [ATT_W-1:0] att_y;
    logic signed [ATT_W-1:0] att_z;

    modport source (output valid, att_w, att_x, att_y, att_z, input ready);
    modport sink   (input valid, att_w, att_x, att_y, att_z, output ready);
endinterface

/* design/quaternion_gyro_integrate.sv */
// Channel   Dir  Word                                     Handshake
// i_gyro    in   rate_x, rate_y, rate_z, interval_us      valid/ready
// o_att     out  att_w, att_x, att_y, att_z (signed Q)    valid/ready
//
// A sample is accepted in the idle cycle, then 32 sequencer steps feed one
// unsigned multiplier, and the emit state loads the output register. A new
// sample is accepted only after the last word has been loaded for output.
// Reset sets the stored attitude to identity and empties the output.
// A result waits in the output register; if it is still unread when the
// next one is ready, the sequencer holds until the word is taken.
module quaternion_gyro_integrate import qgi_pkg::*; #(
    parameter int QUAT_FRAC_BITS = 30
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qgi_in_if.sink    i_gyro,
    qgi_out_if.source o_att
);

    localparam int Q  = QUAT_FRAC_BITS;
    localparam int QW = Q + 2;
    localparam int MW = (Q + 2 > GAIN_W) ? Q + 2 : GAIN_W;
    localparam int PW = 2 * MW;
    localparam int AW = Q + 6;
    localparam int NW = Q + 6;
    localparam int RW = Q + 7;
    localparam int FW = Q + 4;
    localparam int SH = 61 - Q;

    localparam logic signed [QW-1:0] ONE_Q      = QW'(64'd1 << Q);
    localparam logic        [FW-1:0] ONE_MAG    = FW'(64'd1 << Q);
    localparam logic signed [AW-1:0] V_LIM      = AW'((64'd1 << (Q + 2)) - 64'd1);
    localparam logic signed [AW-1:0] V_LIM_N    = -V_LIM;
    localparam logic        [PW:0]   RND_Q      = (PW + 1)'(64'd1 << (Q - 1));
    localparam logic [HACC_W-1:0]    RND_D      = HACC_W'(64'd1 << (SH - 1));
    localparam logic signed [RW-1:0] THREE_HALF = RW'(64'd3 << (Q - 1));
    localparam logic signed [RW-1:0] R_MIN      = RW'(-(64'sd1 <<< (Q + 1)));
    localparam logic        [QW-1:0] R_MIN_MAG  = QW'(64'd1 << (Q + 1));

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state                   r_state;
    logic [STEP_W-1:0]        r_step;
    logic                     r_out_valid;
    logic signed [RATE_W-1:0] r_rate [3];
    logic [DT_W-1:0]          r_dt;
    logic [P_W-1:0]           r_p    [3];
    logic [HACC_W-1:0]        r_hacc;
    logic [QW-1:0]            r_dmag [3];
    logic                     r_dneg [3];
    logic signed [QW-1:0]     r_att  [4];
    logic signed [AW-1:0]     r_v    [4];
    logic [NW-1:0]            r_n;
    logic [QW-1:0]            r_rmag;
    logic                     r_rneg;
    logic signed [QW-1:0]     r_out  [4];

    logic                     accept;
    logic                     emit_go;
    t_op                      iss_op;
    t_tag                     iss_tag;
    logic [MW-1:0]            mul_a;
    logic [MW-1:0]            mul_b;
    logic [PW-1:0]            prod;
    t_tag                     wb_tag;

    logic [RATE_W-1:0]        rate_mag [3];
    logic [QW-1:0]            att_mag  [4];
    logic [QW-1:0]            v_mag    [4];
    logic                     v_neg    [4];

    logic [PW:0]              tq;
    logic signed [AW-1:0]     q_term;
    logic [HACC_W-1:0]        d_sum;
    logic [NW-1:0]            n_half;
    logic signed [RW-1:0]     r_full;
    logic [FW-1:0]            f_mag;
    logic [QW-1:0]            f_sat;
    logic signed [QW-1:0]     f_out;

    assign accept       = i_gyro.valid && (r_state == S_IDLE);
    assign i_gyro.ready = (r_state == S_IDLE);
    assign emit_go      = (r_state == S_EMIT) && (!r_out_valid || o_att.ready);

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_gyro.valid) begin
                        r_state <= S_RUN;
                        r_step  <= '0;
                    end
                end
                S_RUN: begin
                    if (r_step == LAST_STEP) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_EMIT: begin
                    if (emit_go) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (emit_go) begin
                r_out_valid <= 1'b1;
            end else if (o_att.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Magnitudes for the operand select; vector parts are clamped first.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rate_mag[i] = r_rate[i][RATE_W-1] ? RATE_W'(-r_rate[i]) : RATE_W'(r_rate[i]);
        end
        for (int i = 0; i < 4; i++) begin
            att_mag[i] = r_att[i][QW-1] ? QW'(-r_att[i]) : QW'(r_att[i]);
            v_neg[i]   = r_v[i][AW-1];
            if (r_v[i] > V_LIM || r_v[i] < V_LIM_N) begin
                v_mag[i] = {QW{1'b1}};
            end else if (v_neg[i]) begin
                v_mag[i] = QW'(-r_v[i]);
            end else begin
                v_mag[i] = QW'(r_v[i]);
            end
        end
    end

    // Operand select for the shared multiplier.
    always_comb begin
        iss_op = op_at(r_step);
        if (r_state != S_RUN) begin
            iss_op.kind = K_NOP;
        end
        mul_a       = '0;
        mul_b       = '0;
        iss_tag.op  = iss_op;
        iss_tag.neg = 1'b0;
        case (iss_op.kind)
            K_RATE: begin
                mul_a       = MW'(rate_mag[iss_op.axis]);
                mul_b       = MW'(r_dt);
                iss_tag.neg = r_rate[iss_op.axis][RATE_W-1];
            end
            K_GAIN_LO: begin
                mul_a = MW'(r_p[iss_op.axis][P_LO_W-1:0]);
                mul_b = MW'(DQ_GAIN);
            end
            K_GAIN_HI: begin
                mul_a = MW'(r_p[iss_op.axis][P_W-1:P_LO_W]);
                mul_b = MW'(DQ_GAIN);
            end
            K_QUAT: begin
                mul_a       = MW'(r_dmag[iss_op.axis]);
                mul_b       = MW'(att_mag[iss_op.qi]);
                iss_tag.neg = r_dneg[iss_op.axis] ^ r_att[iss_op.qi][QW-1] ^ iss_op.sub;
            end
            K_SQUARE: begin
                mul_a = MW'(v_mag[iss_op.vi]);
                mul_b = MW'(v_mag[iss_op.vi]);
            end
            K_FINAL: begin
                mul_a       = MW'(v_mag[iss_op.vi]);
                mul_b       = MW'(r_rmag);
                iss_tag.neg = v_neg[iss_op.vi] ^ r_rneg;
            end
            default: ;
        endcase
    end

    qgi_mul #(
        .MW(MW)
    ) u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .i_tag  (iss_tag),
        .o_prod (prod),
        .o_tag  (wb_tag)
    );

    // Write-back arithmetic on the registered product.
    always_comb begin
        tq     = ((PW + 1)'(prod) + RND_Q) >> Q;
        q_term = AW'(tq);
        d_sum  = r_hacc + (HACC_W'(prod) << P_LO_W);
        n_half = r_n >> 1;
        r_full = THREE_HALF - RW'(n_half);
        f_mag  = FW'(tq);
        f_sat  = (f_mag > ONE_MAG) ? QW'(ONE_MAG) : QW'(f_mag);
        f_out  = wb_tag.neg ? QW'(-f_sat) : QW'(f_sat);
    end

    // Stored attitude, rewritten by the final scaling.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_att[0] <= ONE_Q;
            r_att[1] <= '0;
            r_att[2] <= '0;
            r_att[3] <= '0;
        end else if (wb_tag.op.kind == K_FINAL) begin
            r_att[wb_tag.op.vi] <= f_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rate[0] <= i_gyro.rate_x;
            r_rate[1] <= i_gyro.rate_y;
            r_rate[2] <= i_gyro.rate_z;
            r_dt      <= i_gyro.interval_us;
            r_n       <= '0;
            for (int i = 0; i < 4; i++) begin
                r_v[i] <= AW'(r_att[i]);
            end
        end
        case (wb_tag.op.kind)
            K_RATE: begin
                r_p[wb_tag.op.axis]    <= prod[P_W-1:0];
                r_dneg[wb_tag.op.axis] <= wb_tag.neg;
            end
            K_GAIN_LO: r_hacc <= HACC_W'(prod) + RND_D;
            K_GAIN_HI: r_dmag[wb_tag.op.axis] <= QW'(d_sum >> SH);
            K_QUAT: begin
                if (wb_tag.neg) begin
                    r_v[wb_tag.op.vi] <= r_v[wb_tag.op.vi] - q_term;
                end else begin
                    r_v[wb_tag.op.vi] <= r_v[wb_tag.op.vi] + q_term;
                end
            end
            K_SQUARE: r_n <= r_n + NW'(tq);
            K_NEWTON: begin
                // Newton factor from seed one, limited from below.
                if (r_full < R_MIN) begin
                    r_rmag <= R_MIN_MAG;
                    r_rneg <= 1'b1;
                end else begin
                    r_rmag <= r_full[RW-1] ? QW'(-r_full) : QW'(r_full);
                    r_rneg <= r_full[RW-1];
                end
            end
            default: ;
        endcase
        if (emit_go) begin
            for (int i = 0; i < 4; i++) begin
                r_out[i] <= r_att[i];
            end
        end
    end

    assign o_att.valid = r_out_valid;
    assign o_att.att_w = ATT_W'(r_out[0]);
    assign o_att.att_x = ATT_W'(r_out[1]);
    assign o_att.att_y = ATT_W'(r_out[2]);
    assign o_att.att_z = ATT_W'(r_out[3]);

endmodule

/* design/qgi_mul.sv */
module qgi_mul import qgi_pkg::*; #(
    parameter int MW = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [MW-1:0]   i_a,
    input  logic [MW-1:0]   i_b,
    input  t_tag            i_tag,
    output logic [2*MW-1:0] o_prod,
    output t_tag            o_tag
);

    logic [2*MW-1:0] r_prod;
    t_tag            r_tag;

    // The tag travels with its product so write-back knows where it goes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= (2*MW)'(i_a) * (2*MW)'(i_b);
    end

    assign o_prod = r_prod;
    assign o_tag  = r_tag;

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import qgi_pkg::*;

    localparam int     QF          = 30;
    localparam longint ONE_Q       = 64'sd1 <<< QF;
    localparam longint PROD_LIM    = (64'sd1 <<< (QF + 2)) - 1;
    localparam longint NEWTON_MIN  = -(64'sd1 <<< (QF + 1));
    localparam int     ANGLE_SHIFT = 61 - QF;
    // pi / 360e9 in units of 2^-61
    localparam bit [63:0] ANGLE_GAIN = 64'd20122276;

    localparam logic signed [RATE_W-1:0] RATE_MAX = 23'sh3FFFFF;
    localparam logic signed [RATE_W-1:0] RATE_MIN = 23'sh400000;
    localparam logic        [DT_W-1:0]   DT_MAX   = 16'hFFFF;

    localparam int STALL_LIMIT = 2000;

    typedef struct {
        logic signed [ATT_W-1:0] w;
        logic signed [ATT_W-1:0] x;
        logic signed [ATT_W-1:0] y;
        logic signed [ATT_W-1:0] z;
    } t_att_word;

    logic clk;
    logic rst_n;

    qgi_in_if  gyro_if();
    qgi_out_if att_if();

    quaternion_gyro_integrate #(.QUAT_FRAC_BITS(QF)) i_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_gyro (gyro_if),
        .o_att  (att_if)
    );

    longint    cur_att[4] = '{ONE_Q, 0, 0, 0};
    t_att_word att_expect_q[$];
    int        fault_count  = 0;
    int        stall_cycles = 0;
    int        src_idle_pct = 0;
    int        snk_idle_pct = 0;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic bit [63:0] mag(input longint a);
        return (a < 0) ? 64'(-a) : 64'(a);
    endfunction

    // Divide by 2^sh with rounding half away from zero, sign applied last.
    function automatic longint round_div(input bit [63:0] m, input int sh, input bit neg);
        bit [63:0] r;
        r = (m + (64'd1 << (sh - 1))) >> sh;
        return neg ? -$signed(r) : $signed(r);
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return round_div(mag(a) * mag(b), QF, (a < 0) != (b < 0));
    endfunction

    function automatic longint limit(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint half_angle(input longint rate, input longint dt);
        longint p;
        p = rate * dt;
        return round_div(mag(p) * ANGLE_GAIN, ANGLE_SHIFT, p < 0);
    endfunction

    // Rotate the held attitude by one gyro sample and renormalize it.
    function automatic t_att_word integrate_sample(input longint rx, input longint ry,
                                                   input longint rz, input longint dt);
        longint    d1, d2, d3;
        longint    q0, q1, q2, q3;
        longint    v[4];
        longint    r;
        bit [63:0] n;
        bit [63:0] m;
        int        i;
        t_att_word res;
        d1 = half_angle(rx, dt);
        d2 = half_angle(ry, dt);
        d3 = half_angle(rz, dt);
        q0 = cur_att[0];
        q1 = cur_att[1];
        q2 = cur_att[2];
        q3 = cur_att[3];
        v[0] = q0 - qmul(d1, q1) - qmul(d2, q2) - qmul(d3, q3);
        v[1] = qmul(d1, q0) + q1 + qmul(d3, q2) - qmul(d2, q3);
        v[2] = qmul(d2, q0) - qmul(d3, q1) + q2 + qmul(d1, q3);
        v[3] = qmul(d3, q0) + qmul(d2, q1) - qmul(d1, q2) + q3;
        n = 64'd0;
        for (i = 0; i < 4; i++) begin
            v[i] = limit(v[i], -PROD_LIM, PROD_LIM);
            m = mag(v[i]);
            n += 64'(round_div(m * m, QF, 1'b0));
        end
        r = 3 * (ONE_Q >>> 1) - $signed(n >> 1);
        if (r < NEWTON_MIN) begin
            r = NEWTON_MIN;
        end
        for (i = 0; i < 4; i++) begin
            cur_att[i] = limit(qmul(v[i], r), -ONE_Q, ONE_Q);
        end
        res.w = cur_att[0][ATT_W-1:0];
        res.x = cur_att[1][ATT_W-1:0];
        res.y = cur_att[2][ATT_W-1:0];
        res.z = cur_att[3][ATT_W-1:0];
        return res;
    endfunction

    task automatic compare_component(input string name, input logic signed [ATT_W-1:0] want,
                                     input logic signed [ATT_W-1:0] got);
        if (got !== want) begin
            fault_count++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    // Predicts on every accepted sample and checks every accepted attitude word.
    always @(posedge clk) begin
        t_att_word want;
        bit        moved;
        moved = 1'b0;
        if (gyro_if.valid && gyro_if.ready) begin
            moved = 1'b1;
            att_expect_q.push_back(integrate_sample(gyro_if.rate_x, gyro_if.rate_y,
                                                    gyro_if.rate_z, gyro_if.interval_us));
        end
        if (att_if.valid && att_if.ready) begin
            moved = 1'b1;
            if (att_expect_q.size() == 0) begin
                fault_count++;
                $display("%0t: attitude word with none expected: %0d %0d %0d %0d", $time,
                         att_if.att_w, att_if.att_x, att_if.att_y, att_if.att_z);
            end else begin
                want = att_expect_q.pop_front();
                compare_component("att_w", want.w, att_if.att_w);
                compare_component("att_x", want.x, att_if.att_x);
                compare_component("att_y", want.y, att_if.att_y);
                compare_component("att_z", want.z, att_if.att_z);
            end
        end
        stall_cycles = moved ? 0 : stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("quaternion_gyro_integrate verification failed");
        $finish;
    end

    initial begin
        att_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            att_if.ready = ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance with
    // valid still high, so back-to-back words need no gap.
    task automatic send_sample(input logic signed [RATE_W-1:0] rx,
                               input logic signed [RATE_W-1:0] ry,
                               input logic signed [RATE_W-1:0] rz,
                               input logic        [DT_W-1:0]   dt);
        while ($urandom_range(99) < src_idle_pct) begin
            gyro_if.valid = 1'b0;
            @(negedge clk);
        end
        gyro_if.valid       = 1'b1;
        gyro_if.rate_x      = rx;
        gyro_if.rate_y      = ry;
        gyro_if.rate_z      = rz;
        gyro_if.interval_us = dt;
        do @(posedge clk); while (!gyro_if.ready);
        @(negedge clk);
    endtask

    function automatic logic signed [RATE_W-1:0] small_rate(input int span);
        return RATE_W'(int'($urandom_range(2 * span)) - span);
    endfunction

    function automatic logic signed [RATE_W-1:0] edge_rate();
        case ($urandom_range(3))
            0:       return RATE_MAX;
            1:       return RATE_MIN;
            2:       return '0;
            default: return RATE_W'($urandom());
        endcase
    endfunction

    task automatic test_extreme_rates();
        send_sample(0, 0, 0, DT_MAX);
        send_sample(RATE_MAX, 0, 0, DT_MAX);
        send_sample(RATE_MIN, 0, 0, DT_MAX);
        send_sample(0, RATE_MAX, 0, DT_MAX);
        send_sample(0, RATE_MIN, 0, DT_MAX);
        send_sample(0, 0, RATE_MAX, DT_MAX);
        send_sample(0, 0, RATE_MIN, DT_MAX);
        send_sample(1, -1, 1, 16'd1);
    endtask

    // With no elapsed time the attitude is only renormalized.
    task automatic test_zero_interval();
        send_sample(RATE_MAX, RATE_MIN, RATE_MAX, '0);
        send_sample(0, 0, 0, '0);
        send_sample(12345, -777, 99, '0);
    endtask

    // Full-scale rates on all axes blow up the norm, pin the Newton factor at its
    // floor and clip the outputs; the next one then overflows the raw product.
    task automatic test_saturation();
        send_sample(RATE_MAX, RATE_MAX, RATE_MAX, DT_MAX);
        send_sample(RATE_MIN, RATE_MIN, RATE_MIN, DT_MAX);
        send_sample(RATE_MAX, RATE_MIN, RATE_MAX, DT_MAX);
        send_sample(RATE_MIN, RATE_MAX, RATE_MIN, DT_MAX);
        send_sample(1000, 2000, -3000, 16'd1000);
    endtask

    task automatic test_random_motion(input int count);
        int sel;
        repeat (count) begin
            sel = $urandom_range(99);
            if (sel < 50) begin
                send_sample(small_rate(200000), small_rate(200000), small_rate(200000),
                            DT_W'($urandom_range(4000)));
            end else if (sel < 75) begin
                send_sample(RATE_W'($urandom()), RATE_W'($urandom()), RATE_W'($urandom()),
                            DT_W'($urandom()));
            end else if (sel < 85) begin
                send_sample(RATE_W'($urandom()), RATE_W'($urandom()), RATE_W'($urandom()),
                            '0);
            end else begin
                send_sample(edge_rate(), edge_rate(), edge_rate(),
                            $urandom_range(1) ? DT_MAX : DT_W'($urandom()));
            end
        end
    endtask

    // The sender holds off until the pipeline has fully drained, then resumes.
    task automatic test_drain_hold();
        test_random_motion(4);
        gyro_if.valid = 1'b0;
        wait (att_expect_q.size() == 0);
        @(negedge clk);
        test_random_motion(4);
    endtask

    initial begin
        rst_n               = 1'b0;
        gyro_if.valid       = 1'b0;
        gyro_if.rate_x      = '0;
        gyro_if.rate_y      = '0;
        gyro_if.rate_z      = '0;
        gyro_if.interval_us = '0;
        src_idle_pct        = 15;
        snk_idle_pct        = 62;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_extreme_rates();
        test_zero_interval();
        test_saturation();
        test_random_motion(530);

        src_idle_pct = 62;
        snk_idle_pct = 15;
        test_random_motion(530);
        test_drain_hold();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random_motion(510);

        gyro_if.valid = 1'b0;
        wait (att_expect_q.size() == 0);
        repeat (40) @(posedge clk);
        if (fault_count == 0) begin
            $display("quaternion_gyro_integrate verification clean");
        end else begin
            $display("quaternion_gyro_integrate verification failed");
        end
        $finish;
    end

endmodule
